// ===== src/mlrq_pkg.sv =====
// Shared types and constants for the multilevel ready-queue scheduler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mlrq_pkg;
  localparam int CMD_W = 2;
  localparam int SLOT_W = 6;
  localparam int PRIO_W = 5;
  localparam int CPU_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_READY   = 2'd0,
    CMD_UNREADY = 2'd1,
    CMD_ROTATE  = 2'd2,
    CMD_PICK    = 2'd3
  } cmd_t;

  localparam logic [0:0] REG_FIRST_USER = 1'b0;
  localparam logic [0:0] REG_HW_SLOT    = 1'b1;

  typedef struct packed {
    cmd_t              cmd;
    logic [SLOT_W-1:0] slot;
    logic [PRIO_W-1:0] prio;
    logic [CPU_W-1:0]  cpu;
    logic [CPU_W-1:0]  rcpu;
  } req_t;
endpackage
`default_nettype wire

// ===== src/mlrq_fifo.sv =====
// Short command queue between the front decode and the list engine.
// Depends on mlrq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mlrq_fifo
  import mlrq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  req_t      push_data,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output req_t      pop_data
);
  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== src/mlrq_engine.sv =====
// List engine: ready lists, links and the pick logic, run by a sequencer.
// Depends on mlrq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mlrq_engine
  import mlrq_pkg::*;
#(
  parameter int NUM_SLOTS = 64,
  parameter int NUM_LEVELS = 8,
  parameter int NUM_CPUS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [SLOT_W-1:0] first_user,
  input  wire logic [SLOT_W-1:0] hw_slot,
  input  wire logic              q_empty,
  input  req_t                   q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  output logic [SLOT_W-1:0]      out_current_slot,
  output logic                   out_current_idle,
  output logic [SLOT_W-1:0]      out_previous_slot,
  output logic                   out_previous_idle,
  output logic [SLOT_W-1:0]      out_billed_slot,
  output logic                   out_picked
);
  localparam int LV_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int NL = NUM_CPUS * NUM_LEVELS;
  localparam int LI_W = (NL > 1) ? $clog2(NL) : 1;
  localparam int SI_W = $clog2(NUM_SLOTS);
  localparam int WC_W = $clog2(NUM_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_UHEAD, S_FIND, S_RELINK, S_TREAD, S_TAIL, S_RIX, S_ROT, S_CLR, S_DONE
  } st_t;

  // per slot: {next valid, next link} and {cpu, level}, registered reads
  logic [SLOT_W:0]        link_mem_r [NUM_SLOTS];
  logic [CPU_W+LV_W-1:0]  place_mem_r [NUM_SLOTS];
  logic [SLOT_W:0]        lk_rd_r;
  logic [CPU_W+LV_W-1:0]  pl_rd_r;

  logic [SLOT_W-1:0] head_r [NL];
  logic              hvalid_r [NL];
  logic [SLOT_W-1:0] tail_r [NL];

  st_t               st_r;
  req_t              req_r;
  logic [LI_W-1:0]   ix_r;
  logic [SLOT_W-1:0] x_r;
  logic [WC_W-1:0]   n_r;
  logic [SLOT_W-1:0] run_r, prv_r, bill_r;
  logic              runi_r, prvi_r, picked_r, sel_r;

  // clamp priority
  logic [LV_W-1:0] lv_c;
  always_comb begin
    if (q_data.prio[PRIO_W-1]) lv_c = '0;
    else if (32'(q_data.prio) >= NUM_LEVELS) lv_c = LV_W'(NUM_LEVELS - 1);
    else lv_c = LV_W'(q_data.prio);
  end

  logic ok_c;
  assign ok_c = (32'(q_data.slot) < NUM_SLOTS) && (32'(q_data.cpu) < NUM_CPUS);

  logic [LI_W-1:0] qix_c;
  assign qix_c = LI_W'(32'(q_data.cpu) * NUM_LEVELS + 32'(lv_c));

  logic [SLOT_W-1:0] lk_link_c;
  logic              lk_valid_c;
  assign lk_link_c = lk_rd_r[SLOT_W-1:0];
  assign lk_valid_c = lk_rd_r[SLOT_W];

  // rotate list of the running slot, from the place read of run_r
  logic [SI_W-1:0] rs_c;
  logic [31:0]     rix_c;
  assign rs_c = SI_W'(run_r);
  assign rix_c = 32'(pl_rd_r[LV_W +: CPU_W]) * NUM_LEVELS + 32'(pl_rd_r[LV_W-1:0]);

  // pick: lowest-numbered nonempty level of the running cpu
  logic              pfound_c;
  logic [SLOT_W-1:0] pslot_c;
  always_comb begin
    pfound_c = 1'b0;
    pslot_c = '0;
    if (32'(req_r.rcpu) < NUM_CPUS) begin
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
        if (hvalid_r[LI_W'(32'(req_r.rcpu) * NUM_LEVELS + l)]) begin
          pfound_c = 1'b1;
          pslot_c = head_r[LI_W'(32'(req_r.rcpu) * NUM_LEVELS + l)];
        end
      end
    end
  end

  assign q_pop = (st_r == S_IDLE) && !q_empty;

  // link memory port control: one read and one write address per cycle
  logic [SI_W-1:0] lk_ra_c, lk_wa_c;
  logic [SLOT_W:0] lk_wd_c;
  logic            lk_we_c, pl_we_c;
  always_comb begin
    lk_ra_c = SI_W'(x_r);
    lk_we_c = 1'b0;
    lk_wa_c = SI_W'(x_r);
    lk_wd_c = '0;
    pl_we_c = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        lk_ra_c = SI_W'(head_r[qix_c]);
        if (!q_empty && q_data.cmd == CMD_READY && ok_c) begin
          pl_we_c = 1'b1;
          if (hvalid_r[qix_c]) begin
            lk_we_c = 1'b1;
            lk_wa_c = SI_W'(tail_r[qix_c]);
            lk_wd_c = {1'b1, q_data.slot};
          end
        end
      end
      S_FIND, S_TAIL: lk_ra_c = SI_W'(lk_link_c);
      S_RELINK: begin
        lk_we_c = 1'b1;
        lk_wd_c = lk_rd_r;
      end
      S_RIX: lk_ra_c = SI_W'(head_r[LI_W'(rix_c)]);
      S_ROT: begin
        if (hvalid_r[ix_r] && lk_valid_c) begin
          lk_we_c = 1'b1;
          lk_wa_c = SI_W'(tail_r[ix_r]);
          lk_wd_c = {1'b1, head_r[ix_r]};
        end
      end
      S_CLR: lk_we_c = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lk_we_c) link_mem_r[lk_wa_c] <= lk_wd_c;
    if (pl_we_c) place_mem_r[SI_W'(q_data.slot)] <= {q_data.cpu, lv_c};
    lk_rd_r <= link_mem_r[lk_ra_c];
    pl_rd_r <= place_mem_r[rs_c];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      for (int i = 0; i < NL; i++) hvalid_r[i] <= 1'b0;
      run_r <= '0;
      runi_r <= 1'b1;
      prv_r <= '0;
      prvi_r <= 1'b1;
      bill_r <= hw_slot;
      out_valid <= 1'b0;
      sel_r <= 1'b0;
      picked_r <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (!q_empty) begin
            req_r <= q_data;
            ix_r <= qix_c;
            picked_r <= 1'b0;
            sel_r <= 1'b0;
            st_r <= S_DONE;
            unique case (q_data.cmd)
              CMD_READY: begin
                if (ok_c) begin
                  if (!hvalid_r[qix_c]) begin
                    head_r[qix_c] <= q_data.slot;
                    hvalid_r[qix_c] <= 1'b1;
                  end
                  tail_r[qix_c] <= q_data.slot;
                  // the new tail's link is cleared next cycle
                  x_r <= q_data.slot;
                  st_r <= S_CLR;
                end
              end
              CMD_UNREADY: begin
                if (ok_c && hvalid_r[qix_c]) begin
                  if (head_r[qix_c] == q_data.slot) begin
                    st_r <= S_UHEAD;
                  end else begin
                    x_r <= head_r[qix_c];
                    n_r <= '0;
                    st_r <= S_FIND;
                  end
                end
              end
              CMD_ROTATE: begin
                if (!runi_r) st_r <= S_RIX;
              end
              CMD_PICK: sel_r <= 1'b1;
              default: ;
            endcase
          end
        end
        S_UHEAD: begin
          hvalid_r[ix_r] <= lk_valid_c;
          head_r[ix_r] <= lk_link_c;
          sel_r <= 1'b1;
          st_r <= S_DONE;
        end
        S_RIX: begin
          if (rix_c < NL) begin
            ix_r <= LI_W'(rix_c);
            st_r <= S_ROT;
          end else begin
            st_r <= S_DONE;
          end
        end
        S_ROT: begin
          if (hvalid_r[ix_r] && lk_valid_c) begin
            tail_r[ix_r] <= head_r[ix_r];
            // a one-slot loop keeps its head
            head_r[ix_r] <= (tail_r[ix_r] == head_r[ix_r]) ? head_r[ix_r] : lk_link_c;
            x_r <= head_r[ix_r];
            sel_r <= 1'b1;
            st_r <= S_CLR;
          end else begin
            st_r <= S_DONE;
          end
        end
        S_CLR: st_r <= S_DONE;
        S_FIND: begin
          if (n_r == WC_W'(NUM_SLOTS) || !lk_valid_c) st_r <= S_DONE;
          else if (lk_link_c == req_r.slot) st_r <= S_RELINK;
          else begin
            x_r <= lk_link_c;
            n_r <= n_r + 1'b1;
          end
        end
        S_RELINK: begin
          n_r <= '0;
          st_r <= S_TREAD;
        end
        S_TREAD: st_r <= S_TAIL;
        S_TAIL: begin
          if (n_r == WC_W'(NUM_SLOTS) || !lk_valid_c) begin
            tail_r[ix_r] <= x_r;
            st_r <= S_DONE;
          end else begin
            x_r <= lk_link_c;
            n_r <= n_r + 1'b1;
          end
        end
        S_DONE: begin
          if (sel_r) begin
            picked_r <= 1'b1;
            prv_r <= run_r;
            prvi_r <= runi_r;
            if (pfound_c) begin
              run_r <= pslot_c;
              runi_r <= 1'b0;
              if (pslot_c >= first_user) bill_r <= pslot_c;
            end else begin
              run_r <= hw_slot;
              runi_r <= 1'b1;
              bill_r <= hw_slot;
            end
          end
          out_valid <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_current_slot = run_r;
  assign out_current_idle = runi_r;
  assign out_previous_slot = prv_r;
  assign out_previous_idle = prvi_r;
  assign out_billed_slot = bill_r;
  assign out_picked = picked_r;
endmodule
`default_nettype wire

// ===== src/multilevel_ready_queue_scheduler.sv =====
// Top level of the multilevel ready-queue scheduler.
// Depends on mlrq_pkg, mlrq_fifo and mlrq_engine.
`timescale 1ns / 1ps
`default_nettype none
// A command item is taken when start is high and busy is low. It enters a
// two-entry queue; the list engine takes items from it one at a time.
// Each item yields exactly one result, shown for one cycle with out_valid.
// With the engine free, a pick passes its idle and done states; make-ready
// adds a link clear, make-unready of a head a head update, and rotate an
// index read, the rotation and a link clear. Make-unready of a non-head
// slot walks the list from the head to the slot's predecessor and on to
// the new tail, one link per cycle; the engine takes no new item until
// done. busy is high while the queue is full. Results cannot be stalled.
// Reset empties all lists, makes the block idle and sets first_user_slot
// to 16 and hardware_slot to 7. Config writes take effect in the next cycle.
module multilevel_ready_queue_scheduler
  import mlrq_pkg::*;
#(
  parameter int NUM_SLOTS = 64,
  parameter int NUM_LEVELS = 8,
  parameter int NUM_CPUS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [CMD_W-1:0]  in_command,
  input  wire logic [SLOT_W-1:0] in_process_slot,
  input  wire logic [PRIO_W-1:0] in_priority_req,
  input  wire logic [CPU_W-1:0]  in_target_cpu,
  input  wire logic [CPU_W-1:0]  in_running_cpu,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [SLOT_W-1:0] cfg_data,
  output logic                   out_valid,
  output logic [SLOT_W-1:0]      out_current_slot,
  output logic                   out_current_idle,
  output logic [SLOT_W-1:0]      out_previous_slot,
  output logic                   out_previous_idle,
  output logic [SLOT_W-1:0]      out_billed_slot,
  output logic                   out_picked
);
  logic [SLOT_W-1:0] first_user_r, hw_slot_r;
  req_t req_c, q_data;
  logic q_full, q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_user_r <= SLOT_W'(16);
      hw_slot_r <= SLOT_W'(7);
    end else if (cfg_we) begin
      if (cfg_index == REG_FIRST_USER) first_user_r <= cfg_data;
      else hw_slot_r <= cfg_data;
    end
  end

  always_comb begin
    req_c.cmd = cmd_t'(in_command);
    req_c.slot = in_process_slot;
    req_c.prio = in_priority_req;
    req_c.cpu = in_target_cpu;
    req_c.rcpu = in_running_cpu;
  end

  assign busy = q_full;

  mlrq_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(start && !q_full), .push_data(req_c),
    .full(q_full), .pop(q_pop), .empty(q_empty), .pop_data(q_data)
  );

  mlrq_engine #(
    .NUM_SLOTS(NUM_SLOTS), .NUM_LEVELS(NUM_LEVELS), .NUM_CPUS(NUM_CPUS)
  ) u_engine (
    .clk(clk), .rst_n(rst_n), .first_user(first_user_r), .hw_slot(hw_slot_r),
    .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
    .out_valid(out_valid), .out_current_slot(out_current_slot),
    .out_current_idle(out_current_idle), .out_previous_slot(out_previous_slot),
    .out_previous_idle(out_previous_idle), .out_billed_slot(out_billed_slot),
    .out_picked(out_picked)
  );
endmodule
`default_nettype wire
